@@ rtl/core/fern_pkg.sv @@
// ----------------------------------------------------------------------------
// fern_pkg: shared types and constants of the fern point step core
// Payload structs, field widths, register defaults and the fixed-point
// coefficient helper used by the point map.
// ----------------------------------------------------------------------------
package fern_pkg;

  localparam int SEL_W         = 7;
  localparam int POINT_W       = 18;
  localparam int PIXEL_W       = 12;
  localparam int COLOR_W       = 24;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 4;

  localparam int FRACTION_BITS_DEF = 12;

  localparam logic [PIXEL_W-1:0] WIDTH_RST  = 12'd1000;
  localparam logic [PIXEL_W-1:0] HEIGHT_RST = 12'd1000;
  localparam logic [COLOR_W-1:0] COLOR_RST  = 24'h00FF00;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;

  typedef struct packed {
    logic [SEL_W-1:0] random_value;
    logic             restart;
  } fern_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
    logic               visible;
    logic [COLOR_W-1:0] color;
  } fern_out_t;

  // Coefficient given in hundredths, rounded to nearest magnitude at frac_bits.
  function automatic longint coef_fx(input int hundredths, input int frac_bits);
    longint mag;
    longint v;
    mag = (hundredths < 0) ? -longint'(hundredths) : longint'(hundredths);
    v   = (mag * (longint'(1) << frac_bits) + 64'sd50) / 100;
    return (hundredths < 0) ? -v : v;
  endfunction

endpackage

@@ rtl/core/fern_point_map.sv @@
// ----------------------------------------------------------------------------
// fern_point_map: one affine step of the fern
// Selects one of four maps from the random value and applies it to the
// current point in signed fixed point, with rounding and saturation.
// ----------------------------------------------------------------------------
module fern_point_map
  import fern_pkg::*;
#(
  parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
  input  logic [SEL_W-1:0]          sel,
  input  logic                      restart,
  input  logic signed [POINT_W-1:0] x,
  input  logic signed [POINT_W-1:0] y,
  output logic signed [POINT_W-1:0] nx,
  output logic signed [POINT_W-1:0] ny
);

  localparam int CW = FRAC_BITS + 2;        // coefficient
  localparam int PW = CW + POINT_W;         // product
  localparam int SW = FRAC_BITS + 23;       // sum
  localparam int QW = SW - FRAC_BITS;       // rounded sum

  localparam logic signed [QW-1:0] Q_MAX = QW'(131071);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(131072);

  typedef enum logic [1:0] {
    MAP_STEM,
    MAP_LEAF_L,
    MAP_LEAF_R,
    MAP_MAIN
  } map_t;

  map_t map;

  logic signed [CW-1:0] ax, bx, ay, by, cy;
  logic signed [POINT_W-1:0] xs, ys;
  logic signed [PW-1:0] p_ax, p_bx, p_ay, p_by;
  logic signed [SW-1:0] s_x, s_y;
  logic signed [SW-1:0] half;
  logic signed [QW-1:0] q_x, q_y;

  always_comb begin
    unique case (sel) inside
      7'd0:          map = MAP_STEM;
      [7'd1:7'd7]:   map = MAP_LEAF_L;
      [7'd8:7'd15]:  map = MAP_LEAF_R;
      default:       map = MAP_MAIN;
    endcase
  end

  always_comb begin
    unique case (map)
      MAP_STEM: begin
        ax = '0;
        bx = '0;
        ay = '0;
        by = CW'(coef_fx(16, FRAC_BITS));
        cy = '0;
      end
      MAP_LEAF_L: begin
        ax = CW'(coef_fx(-15, FRAC_BITS));
        bx = CW'(coef_fx(28, FRAC_BITS));
        ay = CW'(coef_fx(26, FRAC_BITS));
        by = CW'(coef_fx(24, FRAC_BITS));
        cy = CW'(coef_fx(44, FRAC_BITS));
      end
      MAP_LEAF_R: begin
        ax = CW'(coef_fx(20, FRAC_BITS));
        bx = CW'(coef_fx(-26, FRAC_BITS));
        ay = CW'(coef_fx(23, FRAC_BITS));
        by = CW'(coef_fx(22, FRAC_BITS));
        cy = CW'(coef_fx(160, FRAC_BITS));
      end
      default: begin
        ax = CW'(coef_fx(85, FRAC_BITS));
        bx = CW'(coef_fx(4, FRAC_BITS));
        ay = CW'(coef_fx(-4, FRAC_BITS));
        by = CW'(coef_fx(85, FRAC_BITS));
        cy = CW'(coef_fx(160, FRAC_BITS));
      end
    endcase
  end

  // Restart clears the point before the map applies
  assign xs = restart ? '0 : x;
  assign ys = restart ? '0 : y;

  assign p_ax = PW'(ax) * PW'(xs);
  assign p_bx = PW'(bx) * PW'(ys);
  assign p_ay = PW'(ay) * PW'(xs);
  assign p_by = PW'(by) * PW'(ys);

  assign half = SW'(1) <<< (FRAC_BITS - 1);

  assign s_x = SW'(p_ax) + SW'(p_bx) + half;
  assign s_y = SW'(p_ay) + SW'(p_by) + (SW'(cy) <<< FRAC_BITS) + half;

  // Floor shift completes round-half-up
  assign q_x = QW'(s_x >>> FRAC_BITS);
  assign q_y = QW'(s_y >>> FRAC_BITS);

  always_comb begin
    if (q_x > Q_MAX) begin
      nx = POINT_W'(Q_MAX);
    end else if (q_x < Q_MIN) begin
      nx = POINT_W'(Q_MIN);
    end else begin
      nx = POINT_W'(q_x);
    end
    if (q_y > Q_MAX) begin
      ny = POINT_W'(Q_MAX);
    end else if (q_y < Q_MIN) begin
      ny = POINT_W'(Q_MIN);
    end else begin
      ny = POINT_W'(q_y);
    end
  end

endmodule

@@ rtl/core/fern_pixel.sv @@
// ----------------------------------------------------------------------------
// fern_pixel: point coordinate to screen pixel
// Scales one coordinate, adds the screen origin, truncates toward zero,
// clamps to the pixel range and checks it against the screen size.
// ----------------------------------------------------------------------------
module fern_pixel
  import fern_pkg::*;
#(
  parameter int FRAC_BITS = FRACTION_BITS_DEF,
  parameter int SCALE     = 30
) (
  input  logic signed [POINT_W-1:0] coord,
  input  logic [PIXEL_W-1:0]        origin,
  input  logic [PIXEL_W-1:0]        size,
  output logic [PIXEL_W-1:0]        pix,
  output logic                      vis
);

  localparam int TW  = FRAC_BITS + 25;
  localparam int QW  = TW - FRAC_BITS;
  localparam int MW  = POINT_W + 7;

  localparam logic signed [6:0]    SCALE_C = 7'(SCALE);
  localparam logic signed [QW-1:0] PIX_MAX = QW'(4095);

  logic signed [MW-1:0] prod;
  logic signed [TW-1:0] t;
  logic signed [TW-1:0] t_adj;
  logic signed [QW-1:0] q;

  assign prod  = MW'(coord) * MW'(SCALE_C);
  assign t     = TW'(prod) + (TW'({1'b0, origin}) <<< FRAC_BITS);
  // Bias negatives so the shift truncates toward zero
  assign t_adj = t + (t[TW-1] ? ((TW'(1) <<< FRAC_BITS) - TW'(1)) : TW'(0));
  assign q     = QW'(t_adj >>> FRAC_BITS);

  assign vis = !q[QW-1] && (q < QW'({1'b0, size}));

  always_comb begin
    if (q[QW-1]) begin
      pix = '0;
    end else if (q > PIX_MAX) begin
      pix = '1;
    end else begin
      pix = q[PIXEL_W-1:0];
    end
  end

endmodule

@@ rtl/core/fern_ifs_point_step_core.sv @@
// ----------------------------------------------------------------------------
// fern_ifs_point_step_core: Barnsley fern point generator, one point per step
// Each input transaction picks an affine map from its random value, moves the
// stored fern point and emits one screen pixel with visibility and color.
//
// Usage:
//   in_*   : random_value (0..99) and restart; restart clears the point to
//            the origin before the map applies.
//   out_*  : one result per input transaction: pixel_x, pixel_y (clamped to
//            0..4095), visible, color.
//   APB    : pready tied high. Registers 0x0 screen_width, 0x4 screen_height,
//            0x8 point_color. Write only while no transaction is in flight.
// Timing: an accepted transaction updates the point register; its result then
//   passes into the result register, which drives out_*. One transaction per
//   clock sustained while out_ready is high: the map is one pass into the
//   point register, and the pixel conversion feeds the result register.
// Reset (rst_n low, synchronous): point cleared, pipeline emptied, registers
//   back to 1000 x 1000 and green. Stall: while out_ready is low the result
//   holds; one more transaction enters the point stage, then in_ready drops.
// ----------------------------------------------------------------------------
module fern_ifs_point_step_core
  import fern_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fern_in_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output fern_out_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PIXEL_W-1:0] width_r;
  logic [PIXEL_W-1:0] height_r;
  logic [COLOR_W-1:0] color_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      color_r  <= COLOR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= pwdata[PIXEL_W-1:0];
        REG_HEIGHT: height_r <= pwdata[PIXEL_W-1:0];
        REG_COLOR:  color_r  <= pwdata[COLOR_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_r);
      REG_COLOR:  prdata = CFG_DATA_W'(color_r);
      default:    prdata = '0;
    endcase
  end

  // Screen origin: width / 2 is a shift; height / 3 uses 2731 / 2^13, exact
  // for every 12-bit height.
  logic [PIXEL_W-1:0] origin_x;
  logic [PIXEL_W-1:0] origin_y;
  logic [23:0]        third_prod;

  assign origin_x   = width_r >> 1;
  assign third_prod = 24'(height_r) * 24'd2731;
  assign origin_y   = PIXEL_W'(third_prod[23:13]);

  // --------------------------------------------------------------------------
  // Handshake: point stage feeds the result register
  // --------------------------------------------------------------------------
  logic pt_valid_r;
  logic out_valid_r;
  logic out_load;
  logic in_accept;

  assign out_load  = pt_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !pt_valid_r || out_load;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        pt_valid_r <= 1'b1;
      end else if (out_load) begin
        pt_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Point stage: the fern state doubles as the stage register
  // --------------------------------------------------------------------------
  logic signed [POINT_W-1:0] point_x_r, point_y_r;
  logic signed [POINT_W-1:0] point_x_nxt, point_y_nxt;

  fern_point_map #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_map (
    .sel     (in_data.random_value),
    .restart (in_data.restart),
    .x       (point_x_r),
    .y       (point_y_r),
    .nx      (point_x_nxt),
    .ny      (point_y_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_x_r <= '0;
      point_y_r <= '0;
    end else if (in_accept) begin
      point_x_r <= point_x_nxt;
      point_y_r <= point_y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel stage into the result register
  // --------------------------------------------------------------------------
  logic [PIXEL_W-1:0] pix_x, pix_y;
  logic               vis_x, vis_y;
  fern_out_t          out_data_r;

  fern_pixel #(
    .FRAC_BITS (FRACTION_BITS),
    .SCALE     (30)
  ) u_pix_x (
    .coord  (point_x_r),
    .origin (origin_x),
    .size   (width_r),
    .pix    (pix_x),
    .vis    (vis_x)
  );

  fern_pixel #(
    .FRAC_BITS (FRACTION_BITS),
    .SCALE     (50)
  ) u_pix_y (
    .coord  (point_y_r),
    .origin (origin_y),
    .size   (height_r),
    .pix    (pix_y),
    .vis    (vis_y)
  );

  // Payload holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pixel_x <= pix_x;
      out_data_r.pixel_y <= pix_y;
      out_data_r.visible <= vis_x && vis_y;
      out_data_r.color   <= color_r;
    end
  end

  assign out_data = out_data_r;

endmodule

@@ tb/fern_ifs_point_step_core_tb.sv @@
// ----------------------------------------------------------------------------
// fern_ifs_point_step_core_tb: self-checking bench for the fern point step core
// Drives map selectors and restarts through the input channel, tracks the fern
// point in fixed point alongside the block and checks every pixel, visibility
// flag and color. Screen size and color change between phases over the APB
// port, and both channels stall at random until the final phase.
// ----------------------------------------------------------------------------
module fern_ifs_point_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fern_pkg::*;

  localparam int FB       = FRACTION_BITS_DEF;
  localparam int PT_MAX   = 131071;
  localparam int PT_MIN   = -131072;
  localparam int PIX_LAST = 4095;

  typedef enum logic [1:0] {
    MAP_STEM,
    MAP_LEAF_LEFT,
    MAP_LEAF_RIGHT,
    MAP_MAIN
  } fern_map_t;

  // --------------------------------------------------------------------------
  // Fern point tracker: mirrors the point register and the screen registers,
  // queues the expected pixel of every accepted transaction.
  // --------------------------------------------------------------------------
  class fern_pixel_scoreboard;
    fern_out_t              expected_pixels[$];
    logic signed [POINT_W-1:0] pt_x, pt_y;
    logic [PIXEL_W-1:0]     scr_width, scr_height;
    logic [COLOR_W-1:0]     scr_color;
    int unsigned            failures, checked, restarts, wild_sel, offscreen;

    function new();
      pt_x = '0;
      pt_y = '0;
      scr_width  = WIDTH_RST;
      scr_height = HEIGHT_RST;
      scr_color  = COLOR_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WIDTH:  scr_width  = value[PIXEL_W-1:0];
        REG_HEIGHT: scr_height = value[PIXEL_W-1:0];
        REG_COLOR:  scr_color  = value[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function fern_map_t map_of(logic [SEL_W-1:0] sel);
      if (sel == 0)  return MAP_STEM;
      if (sel <= 7)  return MAP_LEAF_LEFT;
      if (sel <= 15) return MAP_LEAF_RIGHT;
      return MAP_MAIN;
    endfunction

    // hundredths to fixed point, magnitude rounded to nearest
    function longint fx_coef(int hundredths);
      longint mag;
      longint v;
      mag = (hundredths < 0) ? -longint'(hundredths) : longint'(hundredths);
      v   = (mag * (longint'(1) << FB) + 50) / 100;
      return (hundredths < 0) ? -v : v;
    endfunction

    // a*x + b*y + c, round half up back to FB fraction bits, saturate
    function longint affine_fx(int a, longint x, int b, longint y, int c);
      longint one_fx;
      longint s;
      one_fx = longint'(1) << FB;
      s = fx_coef(a) * x + fx_coef(b) * y + fx_coef(c) * one_fx + (one_fx >>> 1);
      s = s >>> FB;
      if (s > PT_MAX) s = PT_MAX;
      if (s < PT_MIN) s = PT_MIN;
      return s;
    endfunction

    // scale*v + origin, truncated toward zero, clamped; clears vis when off screen
    function logic [PIXEL_W-1:0] pixel_of(longint v, int scale, int unsigned span,
                                          int unsigned origin, inout bit vis);
      longint t;
      t = longint'(scale) * v + longint'(origin) * (longint'(1) << FB);
      t = t / (longint'(1) << FB);
      if (t < 0 || t >= longint'(span)) vis = 1'b0;
      if (t < 0) t = 0;
      if (t > PIX_LAST) t = PIX_LAST;
      return t[PIXEL_W-1:0];
    endfunction

    function void note_step(fern_in_t item);
      longint    x, y, nx, ny;
      bit        vis;
      fern_out_t want;
      vis = 1'b1;
      if (item.restart) begin
        pt_x = '0;
        pt_y = '0;
        restarts++;
      end
      if (item.random_value > 99) wild_sel++;
      x = longint'(pt_x);
      y = longint'(pt_y);
      case (map_of(item.random_value))
        MAP_STEM: begin
          nx = 0;
          ny = affine_fx(0, x, 16, y, 0);
        end
        MAP_LEAF_LEFT: begin
          nx = affine_fx(-15, x, 28, y, 0);
          ny = affine_fx(26, x, 24, y, 44);
        end
        MAP_LEAF_RIGHT: begin
          nx = affine_fx(20, x, -26, y, 0);
          ny = affine_fx(23, x, 22, y, 160);
        end
        default: begin
          nx = affine_fx(85, x, 4, y, 0);
          ny = affine_fx(-4, x, 85, y, 160);
        end
      endcase
      pt_x = nx[POINT_W-1:0];
      pt_y = ny[POINT_W-1:0];
      want.pixel_x = pixel_of(nx, 30, scr_width, scr_width / 2, vis);
      want.pixel_y = pixel_of(ny, 50, scr_height, scr_height / 3, vis);
      want.visible = vis;
      want.color   = scr_color;
      if (!vis) offscreen++;
      expected_pixels.push_back(want);
    endfunction

    function void flag_failure(string what, fern_out_t want, fern_out_t got);
      failures++;
      if (failures <= 10)
        $display({"%t %s: expected x=%0d y=%0d vis=%0b col=%06h, ",
                  "got x=%0d y=%0d vis=%0b col=%06h"},
                 $realtime, what, want.pixel_x, want.pixel_y, want.visible, want.color,
                 got.pixel_x, got.pixel_y, got.visible, got.color);
    endfunction

    function void check_pixel(fern_out_t got);
      fern_out_t want;
      if (expected_pixels.size() == 0) begin
        flag_failure("result with no transaction pending", '0, got);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.visible !== want.visible || got.color !== want.color)
        flag_failure("pixel mismatch", want, got);
    endfunction

    function int unsigned outstanding();
      return expected_pixels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  fern_in_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;

  logic                  in_ready;
  logic                  out_valid;
  fern_out_t             out_data;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // set for the last phase: no gaps on the input, no stalls on the output
  bit calm = 1'b0;
  int unsigned phases = 0;

  fern_pixel_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fern_ifs_point_step_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Observe both channels at the edge. Note the input before checking the
  // output so a same-edge pair is ordered the same way on every simulator.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_step(in_data);
      if (out_valid && out_ready) sb.check_pixel(out_data);
    end
  end

  // Result side: stall in random bursts, hold ready high once calm.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One APB write: setup, then access until pready, then the bus returns to idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one transaction, optionally after a random gap; return once taken.
  task automatic send_step(input fern_in_t item);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_data  <= fern_in_t'((SEL_W + 1)'($urandom));  // junk while idle
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly legal selectors with the odd out-of-range one; rare restarts so
  // the point gets to wander over the whole fern between them.
  function automatic fern_in_t random_step();
    fern_in_t item;
    if ($urandom_range(0, 24) == 0)
      item.random_value = SEL_W'($urandom_range(100, 127));
    else
      item.random_value = SEL_W'($urandom_range(0, 99));
    item.restart = ($urandom_range(0, 39) == 0);
    return item;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_step(random_step());
    in_valid <= 1'b0;
  endtask

  // Drain every pending pixel, then let the pipeline settle before touching
  // the registers. The first edge lets the monitor note the last transaction.
  task automatic settle();
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_screen(input logic [11:0] w, input logic [11:0] h,
                            input logic [23:0] col);
    settle();
    write_reg(REG_WIDTH, {20'd0, w});
    write_reg(REG_HEIGHT, {20'd0, h});
    write_reg(REG_COLOR, {8'd0, col});
    phases++;
  endtask

  initial begin
    fern_in_t item;
    int sels[20]     = '{0, 50, 99, 1, 7, 8, 15, 16, 100, 127,
                         0, 64, 2, 12, 85, 127, 96, 3, 9, 0};
    bit restart_at[20] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                           0, 1, 0, 0, 0, 1, 0, 0, 0, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset screen: walk every map boundary, the selector extremes and restart.
    phases++;
    for (int i = 0; i < 20; i++) begin
      item.random_value = SEL_W'(sels[i]);
      item.restart      = restart_at[i];
      send_step(item);
    end
    run_random(100);

    // Largest screen, all-ones color.
    set_screen(12'd4095, 12'd4095, 24'hFFFFFF);
    run_random(80);

    // Single-pixel screen: negative x pixels clamp to zero and go invisible.
    set_screen(12'd1, 12'd1, 24'h000000);
    run_random(60);

    // Zero-sized screen: nothing is visible, pixels still come out.
    set_screen(12'd0, 12'd0, 24'h5A5AA5);
    run_random(40);

    // Small screen where the fern spills over the top edge.
    set_screen(12'd160, 12'd220, 24'($urandom));
    run_random(80);

    // Random screen, full throughput on both sides.
    set_screen(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
               24'($urandom));
    calm = 1'b1;
    run_random(140);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    sb.failures += sb.outstanding();
    $display("checked %0d pixels over %0d screen settings (%0d off screen)",
             sb.checked, phases, sb.offscreen);
    $display("restarts: %0d, selectors above 99: %0d, failures: %0d",
             sb.restarts, sb.wild_sel, sb.failures);
    if (sb.failures == 0)
      $display("[fern_ifs_point_step_core] OK");
    else
      $display("[fern_ifs_point_step_core] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout: %0d pixels still pending", sb.outstanding());
    $display("[fern_ifs_point_step_core] ERROR");
    $finish;
  end

endmodule
